@@ rtl/trd_pkg.sv @@
package trd_pkg;

  // Input transaction: one row byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Output transaction: one parse result
  typedef struct packed {
    logic [1:0]         result_kind;
    logic [4:0]         column_index;
    logic [1:0]         column_type;
    logic               is_null;
    logic signed [63:0] column_value;
    logic [7:0]         text_byte;
    logic [2:0]         error_code;
    logic               last_result;
  } out_item_t;

  // Parse phase of the current row
  typedef enum logic [1:0] {
    PH_BITMAP  = 2'd0,
    PH_FIELD   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAIL   = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] REG_COLUMN_TYPES = 2'd1;

  // Column type codes
  localparam logic [1:0] TYPE_INT32 = 2'd0;
  localparam logic [1:0] TYPE_INT64 = 2'd1;
  localparam logic [1:0] TYPE_BOOL  = 2'd2;
  localparam logic [1:0] TYPE_TEXT  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_SHORT_BITMAP = 3'd0;
  localparam logic [2:0] ERR_TEXT_PAYLOAD = 3'd5;
  localparam logic [2:0] ERR_TRAILING     = 3'd6;

  // Field width in bytes for a type code
  function automatic logic [3:0] field_width(input logic [1:0] t);
    logic [3:0] w;
    case (t)
      TYPE_INT32: w = 4'd4;
      TYPE_INT64: w = 4'd8;
      TYPE_BOOL:  w = 4'd1;
      default:    w = 4'd4;
    endcase
    return w;
  endfunction

  // Truncation error code for a type code
  function automatic logic [2:0] trunc_code(input logic [1:0] t);
    return {1'b0, t} + 3'd1;
  endfunction

  // Type code of a column from the packed type list
  function automatic logic [1:0] col_type(input logic [63:0] list, input logic [4:0] col);
    return list[{col, 1'b0} +: 2];
  endfunction

  function automatic out_item_t mk_res(
    input logic [1:0]  kind,
    input logic [4:0]  col,
    input logic [1:0]  t,
    input logic        isn,
    input logic [63:0] val,
    input logic [7:0]  tb,
    input logic [2:0]  err
  );
    out_item_t r;
    r.result_kind  = kind;
    r.column_index = col;
    r.column_type  = t;
    r.is_null      = isn;
    r.column_value = val;
    r.text_byte    = tb;
    r.error_code   = err;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/tuple_record_decoder.sv @@
// Queueing: a byte's results enter the result queue at the edge that accepts it and are
//   offered on out_data from the next cycle, behind any results already queued.
// Throughput: one byte per cycle while in_stall is low (two or fewer queued results);
//   the output moves one result per cycle unless out_stall, via a four-entry queue.
// Reset (rst_n low, synchronous): parser back at the row start, queue emptied,
//   column_count_r to 1 and column_types_r to 0.
module tuple_record_decoder #(
  parameter int MAX_COLUMNS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import trd_pkg::*;

  localparam logic [5:0] MaxCols = 6'(MAX_COLUMNS);
  localparam int QDepth = 4;

  // Configuration registers
  logic [5:0]  column_count_r;
  logic [63:0] column_types_r;

  // Row parse state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [4:0]  cur_col_r, cur_col_nxt;
  logic [31:0] null_bits_r, null_bits_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] text_rem_r, text_rem_nxt;

  // Result queue
  out_item_t   q_mem [QDepth];
  logic [1:0]  q_wr_r, q_rd_r;
  logic [2:0]  q_cnt_r;

  // Per-byte results
  out_item_t   res [2];
  logic [1:0]  res_cnt;

  logic        in_fire, out_fire;
  logic [5:0]  n_eff;
  logic [6:0]  nb_sum;
  logic [3:0]  nb;
  phase_t      ph;
  logic [7:0]  b;
  logic        last;
  logic [1:0]  t;
  logic [63:0] acc_new;
  logic [63:0] v;
  logic        isn;
  logic        do_adv;
  logic [5:0]  next_col;
  logic [1:0]  next_t;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = (q_cnt_r > 3'(QDepth - 2));
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_data  = q_mem[q_rd_r];
  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= 6'd1;
      column_types_r <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMN_COUNT: column_count_r <= cfg_data[5:0];
        REG_COLUMN_TYPES: column_types_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode one byte: next parse state and up to two results
  always_comb begin
    phase_nxt     = phase_r;
    byte_pos_nxt  = byte_pos_r;
    cur_col_nxt   = cur_col_r;
    null_bits_nxt = null_bits_r;
    acc_nxt       = acc_r;
    text_rem_nxt  = text_rem_r;
    res[0]        = '0;
    res[1]        = '0;
    res_cnt       = 2'd0;
    do_adv        = 1'b0;
    b             = in_data.data_byte;
    last          = in_data.last_byte;
    n_eff         = (column_count_r > MaxCols) ? MaxCols : column_count_r;
    nb_sum        = {1'b0, n_eff} + 7'd7;
    nb            = nb_sum[6:3];
    t             = col_type(column_types_r, cur_col_r);
    acc_new       = acc_r | ({56'd0, b} << {byte_pos_r, 3'b000});
    isn           = null_bits_r[cur_col_r];
    v             = acc_new;
    next_col      = {1'b0, cur_col_r} + 6'd1;
    next_t        = col_type(column_types_r, next_col[4:0]);

    // Skip to trailing when no column is left; the row stays there
    ph = phase_r;
    if (ph == PH_BITMAP && n_eff == 6'd0) ph = PH_TRAIL;
    if (ph == PH_FIELD && {1'b0, cur_col_r} >= n_eff) ph = PH_TRAIL;
    phase_nxt = ph;

    unique case (ph)
      PH_BITMAP: begin
        null_bits_nxt = null_bits_r | ({24'd0, b} << {byte_pos_r[1:0], 3'b000});
        if ({2'd0, byte_pos_r[1:0]} + 4'd1 >= nb) begin
          phase_nxt    = PH_FIELD;
          byte_pos_nxt = 3'd0;
          cur_col_nxt  = 5'd0;
          acc_nxt      = 64'd0;
          if (last) begin
            res[res_cnt[0]] = mk_res(KIND_ERROR, 5'd0, column_types_r[1:0], 1'b0, 64'd0,
                                     8'd0, trunc_code(column_types_r[1:0]));
            res_cnt = res_cnt + 2'd1;
          end
        end else begin
          byte_pos_nxt = {1'b0, byte_pos_r[1:0]} + 3'd1;
          if (last) begin
            res[res_cnt[0]] = mk_res(KIND_ERROR, 5'd0, TYPE_INT32, 1'b0, 64'd0, 8'd0,
                                     ERR_SHORT_BITMAP);
            res_cnt = res_cnt + 2'd1;
          end
        end
      end
      PH_FIELD: begin
        acc_nxt = acc_new;
        if ({1'b0, byte_pos_r} + 4'd1 >= field_width(t)) begin
          case (t)
            TYPE_INT32: v = {{32{acc_new[31]}}, acc_new[31:0]};
            TYPE_BOOL:  v = {63'd0, (acc_new[7:0] != 8'd0)};
            TYPE_TEXT:  v = {32'd0, acc_new[31:0]};
            default:    v = acc_new;
          endcase
          res[res_cnt[0]] = mk_res(KIND_VALUE, cur_col_r, t, isn, isn ? 64'd0 : v, 8'd0,
                                   3'd0);
          res_cnt = res_cnt + 2'd1;
          if (t == TYPE_TEXT && v[31:0] != 32'd0) begin
            phase_nxt    = PH_PAYLOAD;
            text_rem_nxt = v[31:0];
            byte_pos_nxt = 3'd0;
            if (last) begin
              res[res_cnt[0]] = mk_res(KIND_ERROR, cur_col_r, t, 1'b0, 64'd0, 8'd0,
                                       ERR_TEXT_PAYLOAD);
              res_cnt = res_cnt + 2'd1;
            end
          end else begin
            do_adv = 1'b1;
          end
        end else begin
          byte_pos_nxt = byte_pos_r + 3'd1;
          if (last) begin
            res[res_cnt[0]] = mk_res(KIND_ERROR, cur_col_r, t, 1'b0, 64'd0, 8'd0,
                                     trunc_code(t));
            res_cnt = res_cnt + 2'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (!isn) begin
          res[res_cnt[0]] = mk_res(KIND_TEXT, cur_col_r, TYPE_TEXT, 1'b0, 64'd0, b, 3'd0);
          res_cnt = res_cnt + 2'd1;
        end
        if (text_rem_r <= 32'd1) begin
          text_rem_nxt = 32'd0;
          do_adv       = 1'b1;
        end else begin
          text_rem_nxt = text_rem_r - 32'd1;
          if (last) begin
            res[res_cnt[0]] = mk_res(KIND_ERROR, cur_col_r, TYPE_TEXT, 1'b0, 64'd0, 8'd0,
                                     ERR_TEXT_PAYLOAD);
            res_cnt = res_cnt + 2'd1;
          end
        end
      end
      PH_TRAIL: begin
        if (last) begin
          res[res_cnt[0]] = mk_res(KIND_ERROR, 5'd0, TYPE_INT32, 1'b0, 64'd0, 8'd0,
                                   ERR_TRAILING);
          res_cnt = res_cnt + 2'd1;
        end
      end
    endcase

    // Advance to the next column, or finish the row
    if (do_adv) begin
      if (next_col >= n_eff) begin
        if (last) begin
          res[res_cnt[0]] = mk_res(KIND_DONE, 5'd0, TYPE_INT32, 1'b0, 64'd0, 8'd0, 3'd0);
          res_cnt = res_cnt + 2'd1;
        end else begin
          phase_nxt = PH_TRAIL;
        end
      end else begin
        cur_col_nxt  = next_col[4:0];
        phase_nxt    = PH_FIELD;
        byte_pos_nxt = 3'd0;
        acc_nxt      = 64'd0;
        if (last) begin
          res[res_cnt[0]] = mk_res(KIND_ERROR, next_col[4:0], next_t, 1'b0, 64'd0, 8'd0,
                                   trunc_code(next_t));
          res_cnt = res_cnt + 2'd1;
        end
      end
    end

    // Start a new row after the last byte
    if (last) begin
      phase_nxt     = PH_BITMAP;
      byte_pos_nxt  = 3'd0;
      cur_col_nxt   = 5'd0;
      null_bits_nxt = 32'd0;
      acc_nxt       = 64'd0;
      text_rem_nxt  = 32'd0;
    end

    // Mark the final result of this byte
    if (res_cnt == 2'd1) res[0].last_result = 1'b1;
    if (res_cnt == 2'd2) res[1].last_result = 1'b1;
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BITMAP;
      byte_pos_r  <= 3'd0;
      cur_col_r   <= 5'd0;
      null_bits_r <= 32'd0;
      acc_r       <= 64'd0;
      text_rem_r  <= 32'd0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      byte_pos_r  <= byte_pos_nxt;
      cur_col_r   <= cur_col_nxt;
      null_bits_r <= null_bits_nxt;
      acc_r       <= acc_nxt;
      text_rem_r  <= text_rem_nxt;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (res_cnt != 2'd0) q_mem[q_wr_r] <= res[0];
      if (res_cnt == 2'd2) q_mem[q_wr_r + 2'd1] <= res[1];
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 2'd0;
      q_rd_r  <= 2'd0;
      q_cnt_r <= 3'd0;
    end else begin
      if (in_fire) q_wr_r <= q_wr_r + res_cnt;
      if (out_fire) q_rd_r <= q_rd_r + 2'd1;
      q_cnt_r <= q_cnt_r + ((in_fire) ? {1'b0, res_cnt} : 3'd0)
               - {2'd0, out_fire};
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'(QDepth))
    else $error("result queue overflow");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |-> res_cnt != 2'd0)
    else $error("row end produced no result");

  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> phase_r == PH_BITMAP && byte_pos_r == 3'd0)
    else $error("parser did not restart after row end");

  a_payload_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> text_rem_r != 32'd0)
    else $error("payload phase with no bytes left");

endmodule

@@ tb/sv/tuple_record_decoder_check.sv @@
module tuple_record_decoder_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  trd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  trd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 rows_done,
  output int                 error_results
);
  import trd_pkg::*;

  localparam int MAX_COLS = 32;

  // Truncation codes, one per column type
  localparam logic [2:0] ERR_TRUNC_INT32  = 3'd1;
  localparam logic [2:0] ERR_TRUNC_INT64  = 3'd2;
  localparam logic [2:0] ERR_TRUNC_BOOL   = 3'd3;
  localparam logic [2:0] ERR_TRUNC_LENGTH = 3'd4;

  // Shadow registers and row parser state
  logic [5:0]  col_count = 6'd1;
  logic [63:0] col_types = '0;
  phase_t      phase = PH_BITMAP;
  logic [2:0]  pos = '0;
  logic [4:0]  cur_col = '0;
  logic [31:0] nulls = '0;
  logic [63:0] acc = '0;
  logic [31:0] text_left = '0;

  // Results of the byte being decoded, then the queue of pending ones
  out_item_t byte_results[2];
  int        byte_result_cnt;
  out_item_t expected_results[$];

  function automatic int type_bytes(logic [1:0] t);
    case (t)
      TYPE_INT64: return 8;
      TYPE_BOOL:  return 1;
      default:    return 4;
    endcase
  endfunction

  function automatic logic [2:0] trunc_err(logic [1:0] t);
    case (t)
      TYPE_INT32: return ERR_TRUNC_INT32;
      TYPE_INT64: return ERR_TRUNC_INT64;
      TYPE_BOOL:  return ERR_TRUNC_BOOL;
      default:    return ERR_TRUNC_LENGTH;
    endcase
  endfunction

  function automatic logic [1:0] type_at(int col);
    return col_types[2*col +: 2];
  endfunction

  function automatic void clear_row();
    phase     = PH_BITMAP;
    pos       = '0;
    cur_col   = '0;
    nulls     = '0;
    acc       = '0;
    text_left = '0;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [4:0] col, logic [1:0] t, logic isn,
                               logic [63:0] val, logic [7:0] tb, logic [2:0] err);
    out_item_t r;
    r.result_kind  = kind;
    r.column_index = col;
    r.column_type  = t;
    r.is_null      = isn;
    r.column_value = val;
    r.text_byte    = tb;
    r.error_code   = err;
    r.last_result  = 1'b0;
    byte_results[byte_result_cnt] = r;
    byte_result_cnt++;
  endfunction

  // Move past a finished column: row done, trailing bytes, or next field
  function automatic void close_column(int n, logic fin);
    if (int'(cur_col) + 1 >= n) begin
      if (fin) emit(KIND_DONE, '0, '0, 1'b0, '0, '0, '0);
      else phase = PH_TRAIL;
    end else begin
      cur_col = cur_col + 5'd1;
      phase   = PH_FIELD;
      pos     = '0;
      acc     = '0;
      if (fin) emit(KIND_ERROR, cur_col, type_at(cur_col), 1'b0, '0, '0,
                    trunc_err(type_at(cur_col)));
    end
  endfunction

  // Decode one row byte and queue the results it causes
  function automatic void decode_byte(in_item_t it);
    int          n;
    int          p;
    logic [1:0]  t;
    logic [4:0]  col;
    logic [63:0] v;
    logic        isn;
    byte_result_cnt = 0;
    n = (int'(col_count) > MAX_COLS) ? MAX_COLS : int'(col_count);
    if (phase == PH_BITMAP && n == 0) phase = PH_TRAIL;
    if (phase == PH_FIELD && int'(cur_col) >= n) phase = PH_TRAIL;

    case (phase)
      PH_BITMAP: begin
        p = int'(pos[1:0]);
        nulls |= 32'(it.data_byte) << (8 * p);
        if (p + 1 >= (n + 7) / 8) begin
          phase   = PH_FIELD;
          pos     = '0;
          cur_col = '0;
          acc     = '0;
          if (it.last_byte) emit(KIND_ERROR, '0, type_at(0), 1'b0, '0, '0,
                                 trunc_err(type_at(0)));
        end else begin
          pos = 3'(p + 1);
          if (it.last_byte) emit(KIND_ERROR, '0, '0, 1'b0, '0, '0, ERR_SHORT_BITMAP);
        end
      end
      PH_FIELD: begin
        col = cur_col;
        t   = type_at(col);
        p   = int'(pos);
        acc |= 64'(it.data_byte) << (8 * p);
        if (p + 1 >= type_bytes(t)) begin
          isn = nulls[col];
          case (t)
            TYPE_INT32: v = {{32{acc[31]}}, acc[31:0]};
            TYPE_BOOL:  v = (acc[7:0] != 8'd0) ? 64'd1 : 64'd0;
            TYPE_TEXT:  v = {32'd0, acc[31:0]};
            default:    v = acc;
          endcase
          emit(KIND_VALUE, col, t, isn, isn ? 64'd0 : v, '0, '0);
          // A text length of zero closes the column at once
          if (t == TYPE_TEXT && v != 64'd0) begin
            phase     = PH_PAYLOAD;
            text_left = v[31:0];
            pos       = '0;
            if (it.last_byte) emit(KIND_ERROR, col, t, 1'b0, '0, '0, ERR_TEXT_PAYLOAD);
          end else begin
            close_column(n, it.last_byte);
          end
        end else begin
          pos = 3'(p + 1);
          if (it.last_byte) emit(KIND_ERROR, col, t, 1'b0, '0, '0, trunc_err(t));
        end
      end
      PH_PAYLOAD: begin
        col = cur_col;
        // Payload of a null text column is swallowed silently
        if (!nulls[col]) emit(KIND_TEXT, col, TYPE_TEXT, 1'b0, '0, it.data_byte, '0);
        if (text_left <= 32'd1) begin
          text_left = '0;
          close_column(n, it.last_byte);
        end else begin
          text_left = text_left - 32'd1;
          if (it.last_byte) emit(KIND_ERROR, col, TYPE_TEXT, 1'b0, '0, '0, ERR_TEXT_PAYLOAD);
        end
      end
      default: begin
        if (it.last_byte) emit(KIND_ERROR, '0, '0, 1'b0, '0, '0, ERR_TRAILING);
      end
    endcase

    if (it.last_byte) clear_row();
    for (int i = 0; i < byte_result_cnt; i++) begin
      if (i == byte_result_cnt - 1) byte_results[i].last_result = 1'b1;
      expected_results.insert(expected_results.size(), byte_results[i]);
    end
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("kind=%0d col=%0d type=%0d null=%0d value=%016h text=%02h err=%0d last=%0d",
                     r.result_kind, r.column_index, r.column_type, r.is_null,
                     r.column_value, r.text_byte, r.error_code, r.last_result);
  endfunction

  // Predict accepted bytes, track config writes, compare delivered results
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      col_count = 6'd1;
      col_types = '0;
      clear_row();
      expected_results.delete();
    end else begin
      // A byte taken at the same edge as a write still sees the old registers
      if (in_valid && !in_stall) decode_byte(in_data);

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COLUMN_COUNT) col_count = cfg_data[5:0];
        else if (cfg_index == REG_COLUMN_TYPES) col_types = cfg_data;
      end

      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %s", show(got));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.result_kind == KIND_DONE) rows_done++;
          if (got.result_kind == KIND_ERROR) error_results++;
          if (got.result_kind !== want.result_kind || got.column_index !== want.column_index ||
              got.column_type !== want.column_type || got.is_null !== want.is_null ||
              got.column_value !== want.column_value || got.text_byte !== want.text_byte ||
              got.error_code !== want.error_code || got.last_result !== want.last_result) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/sv/tuple_record_decoder_test.sv @@
module tuple_record_decoder_test;
  import trd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_COLUMN_COUNT;
  logic [63:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int rows_done;
  int error_results;

  // Stimulus bookkeeping
  logic [5:0]  cols_set = 6'd1;
  logic [63:0] types_set = '0;
  logic [7:0]  row_q[$];
  int          burst_left = 0;
  bit          steady = 1'b0;
  int          bytes_sent = 0;
  int          rows_sent = 0;
  int          configs_used = 1;

  // Receiver stall control
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_seg = 0;
  int stall_mode = 0;

  always #10 clk = ~clk;

  tuple_record_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tuple_record_decoder_check decode_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .rows_done     (rows_done),
    .error_results (error_results)
  );

  // Stall the result channel in segments of random mode; serve long holds on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall   <= 1'b1;
      hold_left   <= 150;
      hold_served <= hold_asked;
    end else begin
      if (stall_seg == 0) begin
        stall_seg  <= $urandom_range(10, 80);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        stall_seg <= stall_seg - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one byte, idling between bursts, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= b;
    in_data.last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_row();
    for (int i = 0; i < row_q.size(); i++) send_byte(row_q[i], i == row_q.size() - 1);
    rows_sent++;
  endtask

  // Stop sending and wait until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write the column count with random junk above the six used bits
  task automatic write_count(input logic [5:0] cnt);
    logic [63:0] val;
    val      = {$urandom, $urandom};
    val[5:0] = cnt;
    write_reg(REG_COLUMN_COUNT, val);
    cols_set = cnt;
  endtask

  task automatic configure(input logic [5:0] cnt, input logic [63:0] types);
    drain();
    write_count(cnt);
    write_reg(REG_COLUMN_TYPES, types);
    types_set = types;
    configs_used++;
  endtask

  // Pick a new schema; update one register or both
  task automatic new_config();
    logic [5:0]  cnt;
    logic [63:0] types;
    int          which;
    case ($urandom_range(0, 9))
      0:       cnt = 6'd32;
      1:       cnt = 6'($urandom_range(33, 63));
      2:       cnt = 6'd0;
      3:       cnt = 6'd1;
      default: cnt = 6'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 7))
      0:       types = '0;
      1:       types = '1;
      2:       types = {32{TYPE_INT64}};
      3:       types = {32{TYPE_BOOL}};
      default: types = {$urandom, $urandom};
    endcase
    which = $urandom_range(0, 2);
    drain();
    if (which != 1) write_count(cnt);
    if (which != 0) begin
      write_reg(REG_COLUMN_TYPES, types);
      types_set = types;
    end
    configs_used++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'h8000_0000_8000_0000;
      3:       return 64'h7FFF_FFFF_7FFF_FFFF;
      4:       return 64'h0000_0000_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Append one byte to the row being built
  function automatic void add_byte(input logic [7:0] x);
    row_q.insert(row_q.size(), x);
  endfunction

  // Build a well-formed row for the current schema, then maybe damage it
  task automatic build_row();
    int          n;
    int          len;
    int          cut;
    logic [31:0] null_map;
    logic [63:0] v;
    logic [1:0]  t;
    row_q.delete();
    n = (int'(cols_set) > 32) ? 32 : int'(cols_set);
    case ($urandom_range(0, 3))
      0:       null_map = '0;
      1:       null_map = '1;
      default: null_map = $urandom;
    endcase
    for (int i = 0; i < (n + 7) / 8; i++) add_byte(null_map[8*i +: 8]);
    for (int c = 0; c < n; c++) begin
      t = types_set[2*c +: 2];
      v = pick_value();
      case (t)
        TYPE_INT32: for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
        TYPE_INT64: for (int i = 0; i < 8; i++) add_byte(v[8*i +: 8]);
        TYPE_BOOL:  add_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
        default: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
          for (int i = 0; i < 4; i++) add_byte(8'(len >> (8 * i)));
          for (int i = 0; i < len; i++) add_byte(8'($urandom));
        end
      endcase
    end
    if (row_q.size() == 0) add_byte(8'($urandom));

    case ($urandom_range(0, 9))
      // Truncate somewhere inside the row
      0: if (row_q.size() > 1) begin
        cut = $urandom_range(1, row_q.size() - 1);
        while (row_q.size() > cut) void'(row_q.pop_back());
      end
      // Append trailing garbage
      1: repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      // Replace with noise
      2: begin
        row_q.delete();
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      end
      default: ;
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One int32 column at reset: all-ones value, then done
    row_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_row();

    // Null text column: length reported as zero, payload swallowed
    configure(6'd1, {62'd0, TYPE_TEXT});
    row_q = '{8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_row();

    // Nine columns need two bitmap bytes: a single byte is a short bitmap
    configure(6'd9, '0);
    row_q = '{8'h00};
    send_row();

    // No columns: every byte is trailing
    configure(6'd0, '0);
    row_q = '{8'h5A};
    send_row();

    // Bool then int64 cut short
    configure(6'd2, {60'd0, TYPE_INT64, TYPE_BOOL});
    row_q = '{8'h00, 8'h07, 8'h11, 8'h22, 8'h33};
    send_row();

    // Shrink the column count mid-row: the rest of the row is trailing
    configure(6'd2, {60'd0, TYPE_BOOL, TYPE_BOOL});
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    drain();
    write_count(6'd1);
    send_byte(8'h12, 1'b1);
    rows_sent++;

    // Long receiver hold while the sender keeps pushing
    configure(6'd8, {$urandom, $urandom});
    hold_asked <= hold_asked + 1;
    steady = 1'b1;
    repeat (3) begin
      build_row();
      send_row();
    end
    steady = 1'b0;
    drain();

    // Random schemas, mostly well-formed rows
    while (bytes_sent < 2000) begin
      new_config();
      repeat ($urandom_range(3, 10)) begin
        if (bytes_sent < 2000) begin
          build_row();
          send_row();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Streamed %0d bytes in %0d rows over %0d schemas; checked %0d results",
             bytes_sent, rows_sent, configs_used, checked);
    $display("(%0d rows completed cleanly, %0d error results).", rows_done, error_results);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
